### design/tbpg_pkg.sv
package tbpg_pkg;

    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_NAME    = 2'd1;
    localparam logic [1:0] REQ_PALETTE = 2'd2;
    localparam logic [1:0] REQ_RENDER  = 2'd3;

    localparam int PATTERN_DEPTH = 4096;
    localparam int NAME_DEPTH    = 4096;
    localparam int PAL_DEPTH     = 16;

    localparam logic [8:0] SCROLL_Y_WRAP = 9'd480;
    localparam logic [9:0] TABLE_LINES   = 10'd240;
    localparam logic [9:0] ATTR_OFFSET   = 10'd960;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  screen_col;
        logic [7:0]  screen_row;
        logic [8:0]  scroll_x;
        logic [8:0]  scroll_y;
    } req_word_t;

    typedef struct packed {
        logic [5:0] colour_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_word_t;

    // scrolled position, or a store write, leaving the scroll stages
    typedef struct packed {
        logic        valid;
        logic [1:0]  req_type;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [9:0]  x;
        logic [9:0]  y;
    } pos_t;

    // palette result of a render word
    typedef struct packed {
        logic       valid;
        logic [5:0] colour_index;
    } ci_t;

    // 6-bit levels {r, g, b}
    function automatic logic [17:0] colour_level(input logic [5:0] ci);
        logic [17:0] lv;
        case (ci)
            6'd0:    lv = {6'h1D, 6'h1D, 6'h1D};
            6'd1:    lv = {6'h09, 6'h06, 6'h23};
            6'd2:    lv = {6'h00, 6'h00, 6'h2A};
            6'd3:    lv = {6'h11, 6'h00, 6'h27};
            6'd4:    lv = {6'h23, 6'h00, 6'h1D};
            6'd5:    lv = {6'h2A, 6'h00, 6'h04};
            6'd6:    lv = {6'h29, 6'h00, 6'h00};
            6'd7:    lv = {6'h1F, 6'h02, 6'h00};
            6'd8:    lv = {6'h10, 6'h0B, 6'h00};
            6'd9:    lv = {6'h00, 6'h11, 6'h00};
            6'd10:   lv = {6'h00, 6'h14, 6'h00};
            6'd11:   lv = {6'h00, 6'h0F, 6'h05};
            6'd12:   lv = {6'h06, 6'h0F, 6'h17};
            6'd16:   lv = {6'h2F, 6'h2F, 6'h2F};
            6'd17:   lv = {6'h00, 6'h1C, 6'h3B};
            6'd18:   lv = {6'h08, 6'h0E, 6'h3B};
            6'd19:   lv = {6'h20, 6'h00, 6'h3C};
            6'd20:   lv = {6'h2F, 6'h00, 6'h2F};
            6'd21:   lv = {6'h39, 6'h00, 6'h16};
            6'd22:   lv = {6'h36, 6'h0A, 6'h00};
            6'd23:   lv = {6'h32, 6'h13, 6'h03};
            6'd24:   lv = {6'h22, 6'h1C, 6'h00};
            6'd25:   lv = {6'h00, 6'h25, 6'h00};
            6'd26:   lv = {6'h00, 6'h2A, 6'h00};
            6'd27:   lv = {6'h00, 6'h24, 6'h0E};
            6'd28:   lv = {6'h00, 6'h20, 6'h22};
            6'd32:   lv = {6'h3F, 6'h3F, 6'h3F};
            6'd33:   lv = {6'h0F, 6'h2F, 6'h3F};
            6'd34:   lv = {6'h17, 6'h25, 6'h3F};
            6'd35:   lv = {6'h33, 6'h22, 6'h3F};
            6'd36:   lv = {6'h3D, 6'h1E, 6'h3F};
            6'd37:   lv = {6'h3F, 6'h1D, 6'h2D};
            6'd38:   lv = {6'h3F, 6'h1D, 6'h18};
            6'd39:   lv = {6'h3F, 6'h26, 6'h0E};
            6'd40:   lv = {6'h3C, 6'h2F, 6'h0F};
            6'd41:   lv = {6'h20, 6'h34, 6'h04};
            6'd42:   lv = {6'h13, 6'h37, 6'h12};
            6'd43:   lv = {6'h16, 6'h3E, 6'h26};
            6'd44:   lv = {6'h00, 6'h3A, 6'h36};
            6'd45:   lv = {6'h1E, 6'h1E, 6'h1E};
            6'd48:   lv = {6'h3F, 6'h3F, 6'h3F};
            6'd49:   lv = {6'h2A, 6'h39, 6'h3F};
            6'd50:   lv = {6'h31, 6'h35, 6'h3F};
            6'd51:   lv = {6'h35, 6'h32, 6'h3F};
            6'd52:   lv = {6'h3F, 6'h31, 6'h3F};
            6'd53:   lv = {6'h3F, 6'h31, 6'h36};
            6'd54:   lv = {6'h3F, 6'h2F, 6'h2C};
            6'd55:   lv = {6'h3F, 6'h36, 6'h2A};
            6'd56:   lv = {6'h3F, 6'h39, 6'h28};
            6'd57:   lv = {6'h38, 6'h3F, 6'h28};
            6'd58:   lv = {6'h2A, 6'h3C, 6'h2F};
            6'd59:   lv = {6'h2C, 6'h3F, 6'h33};
            6'd60:   lv = {6'h27, 6'h3F, 6'h3C};
            6'd61:   lv = {6'h31, 6'h31, 6'h31};
            default: lv = 18'h0;
        endcase
        return lv;
    endfunction

endpackage

### design/tbpg_scroll.sv
module tbpg_scroll
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               req_valid,
    input  tbpg_pkg::req_word_t req_word,
    output tbpg_pkg::pos_t     pos
);

    logic                s1_valid_reg;
    tbpg_pkg::req_word_t s1_word_reg;
    logic                s2_valid_reg;
    logic [1:0]          s2_type_reg;
    logic [11:0]         s2_addr_reg;
    logic [7:0]          s2_data_reg;
    logic [9:0]          s2_x_reg;
    logic [9:0]          s2_y_reg;

    logic [8:0]          sy_adj;
    logic [9:0]          x_next;
    logic [9:0]          y_next;

    always_comb
    begin
        if (s1_word_reg.scroll_y >= tbpg_pkg::SCROLL_Y_WRAP)
        begin
            sy_adj = s1_word_reg.scroll_y - tbpg_pkg::SCROLL_Y_WRAP;
        end
        else
        begin
            sy_adj = s1_word_reg.scroll_y;
        end
        x_next = {2'b00, s1_word_reg.screen_col} + {1'b0, s1_word_reg.scroll_x};
        y_next = {2'b00, s1_word_reg.screen_row} + {1'b0, sy_adj};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_word_reg <= req_word;
            s2_type_reg <= s1_word_reg.req_type;
            s2_addr_reg <= s1_word_reg.mem_addr;
            s2_data_reg <= s1_word_reg.mem_data;
            s2_x_reg    <= x_next;
            s2_y_reg    <= y_next;
        end
    end

    assign pos = '{valid:    s2_valid_reg,
                   req_type: s2_type_reg,
                   mem_addr: s2_addr_reg,
                   mem_data: s2_data_reg,
                   x:        s2_x_reg,
                   y:        s2_y_reg};

endmodule

### design/tbpg_fetch.sv
module tbpg_fetch
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  tbpg_pkg::pos_t pos,
    output tbpg_pkg::ci_t  ci
);

    logic [7:0] name_mem [tbpg_pkg::NAME_DEPTH];
    logic [7:0] pat_mem  [tbpg_pkg::PATTERN_DEPTH];
    logic [7:0] pal_mem  [tbpg_pkg::PAL_DEPTH];

    // name table stage
    logic [1:0]  sub_sel;
    logic [9:0]  y_sub;
    logic [7:0]  y_mod;
    logic [11:0] tile_addr;
    logic [11:0] attr_addr;

    logic        s3_valid_reg;
    logic [1:0]  s3_type_reg;
    logic [11:0] s3_addr_reg;
    logic [7:0]  s3_data_reg;
    logic [7:0]  s3_tile_reg;
    logic [7:0]  s3_attr_byte_reg;
    logic [2:0]  s3_in_x_reg;
    logic [2:0]  s3_in_y_reg;
    logic [1:0]  s3_quad_reg;

    // pattern stage
    logic [11:0] lo_addr;
    logic [11:0] hi_addr;
    logic [1:0]  attr_next;

    logic        s4_valid_reg;
    logic [1:0]  s4_type_reg;
    logic [11:0] s4_addr_reg;
    logic [7:0]  s4_data_reg;
    logic [7:0]  s4_lo_reg;
    logic [7:0]  s4_hi_reg;
    logic [2:0]  s4_in_x_reg;
    logic [1:0]  s4_attr_reg;

    // palette stage
    logic [3:0]  pal_addr;
    logic        s5_valid_reg;
    logic [5:0]  s5_ci_reg;

    always_comb
    begin
        if (pos.y >= 3 * tbpg_pkg::TABLE_LINES)
        begin
            sub_sel = 2'd3;
            y_sub   = 10'(3 * tbpg_pkg::TABLE_LINES);
        end
        else if (pos.y >= 2 * tbpg_pkg::TABLE_LINES)
        begin
            sub_sel = 2'd2;
            y_sub   = 10'(2 * tbpg_pkg::TABLE_LINES);
        end
        else if (pos.y >= tbpg_pkg::TABLE_LINES)
        begin
            sub_sel = 2'd1;
            y_sub   = tbpg_pkg::TABLE_LINES;
        end
        else
        begin
            sub_sel = 2'd0;
            y_sub   = 10'd0;
        end
        y_mod     = 8'(pos.y - y_sub);
        tile_addr = {sub_sel[0], pos.x[8], y_mod[7:3], pos.x[7:3]};
        attr_addr = {sub_sel[0], pos.x[8], tbpg_pkg::ATTR_OFFSET[9:6], y_mod[7:5], pos.x[7:5]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pos.valid && pos.req_type == tbpg_pkg::REQ_NAME)
            begin
                name_mem[pos.mem_addr] <= pos.mem_data;
            end
            s3_tile_reg      <= name_mem[tile_addr];
            s3_attr_byte_reg <= name_mem[attr_addr];
            s3_type_reg      <= pos.req_type;
            s3_addr_reg      <= pos.mem_addr;
            s3_data_reg      <= pos.mem_data;
            s3_in_x_reg      <= pos.x[2:0];
            s3_in_y_reg      <= y_mod[2:0];
            s3_quad_reg      <= {y_mod[4], pos.x[4]};
        end
    end

    always_comb
    begin
        lo_addr   = {s3_tile_reg, 1'b0, s3_in_y_reg};
        hi_addr   = {s3_tile_reg, 1'b1, s3_in_y_reg};
        attr_next = s3_attr_byte_reg[{s3_quad_reg, 1'b0} +: 2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s3_valid_reg && s3_type_reg == tbpg_pkg::REQ_PATTERN)
            begin
                pat_mem[s3_addr_reg] <= s3_data_reg;
            end
            s4_lo_reg   <= pat_mem[lo_addr];
            s4_hi_reg   <= pat_mem[hi_addr];
            s4_type_reg <= s3_type_reg;
            s4_addr_reg <= s3_addr_reg;
            s4_data_reg <= s3_data_reg;
            s4_in_x_reg <= s3_in_x_reg;
            s4_attr_reg <= attr_next;
        end
    end

    // bit 7 is the leftmost pixel
    assign pal_addr = {s4_attr_reg, s4_hi_reg[~s4_in_x_reg], s4_lo_reg[~s4_in_x_reg]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s4_valid_reg && s4_type_reg == tbpg_pkg::REQ_PALETTE)
            begin
                pal_mem[s4_addr_reg[3:0]] <= s4_data_reg;
            end
            s5_ci_reg <= pal_mem[pal_addr][5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= pos.valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg && s4_type_reg == tbpg_pkg::REQ_RENDER;
        end
    end

    assign ci = '{valid: s5_valid_reg, colour_index: s5_ci_reg};

endmodule

### design/tbpg_out.sv
module tbpg_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  tbpg_pkg::ci_t       ci,
    output logic                en,
    output logic                pix_valid,
    input  logic                pix_ready,
    output tbpg_pkg::pix_word_t pix_word
);

    logic                out_valid_reg;
    tbpg_pkg::pix_word_t out_word_reg;
    logic                skid_valid_reg;
    tbpg_pkg::pix_word_t skid_word_reg;

    logic [17:0]         level;
    tbpg_pkg::pix_word_t word_next;
    logic                emit;
    logic                take;

    always_comb
    begin
        level     = tbpg_pkg::colour_level(ci.colour_index);
        word_next = '{colour_index: ci.colour_index,
                      red:          {level[17:12], 2'b00},
                      green:        {level[11:6], 2'b00},
                      blue:         {level[5:0], 2'b00}};
    end

    assign en   = !skid_valid_reg;
    assign emit = ci.valid && en;
    assign take = !out_valid_reg || pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg || emit;
            skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : word_next;
        end
        else if (emit)
        begin
            skid_word_reg <= word_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_word  = out_word_reg;

endmodule

### design/tile_background_pixel_generator_core.sv
// channel | handshake            | payload                        | moves
// req     | req_valid, req_ready | req_word (tbpg_pkg::req_word_t) | store write or render word
// pix     | pix_valid, pix_ready | pix_word (tbpg_pkg::pix_word_t) | one pixel per render word
//
// One word per cycle while req_ready is high; a render word passes through the input
// register, scroll add, table wrap with name table read, pattern read, palette read
// and colour lookup before its pixel appears on pix.
// Write words update their store in the stage that reads it, so order is kept.
// rst_n clears valid bits only; stores are undefined until written.
// A two-entry output buffer holds results; req_ready drops only while both are full,
// and the whole pipeline then holds.
module tile_background_pixel_generator_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tbpg_pkg::req_word_t req_word,
    output logic                pix_valid,
    input  logic                pix_ready,
    output tbpg_pkg::pix_word_t pix_word
);

    logic           en;
    tbpg_pkg::pos_t pos;
    tbpg_pkg::ci_t  ci;

    tbpg_scroll u_scroll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req_word  (req_word),
        .pos       (pos)
    );

    tbpg_fetch u_fetch
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .pos   (pos),
        .ci    (ci)
    );

    tbpg_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ci        (ci),
        .en        (en),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_word  (pix_word)
    );

    assign req_ready = en;

endmodule

### design/tbpg_checker.sv
module tbpg_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                pix_valid,
    input logic                pix_ready,
    input tbpg_pkg::pix_word_t pix_word
);

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_word))
        else $error("pix word changed while stalled");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !pix_valid && req_ready)
        else $error("pipeline not empty after reset");

    a_ready_low_waits: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> pix_valid)
        else $error("req_ready low with no pixel waiting");

    a_ready_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready && pix_ready |=> req_ready)
        else $error("req_ready stuck after pixel taken");

    a_no_pix_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid && !(req_valid && req_ready) &&
        $past(!pix_valid && !(req_valid && req_ready), 1) &&
        $past(!pix_valid && !(req_valid && req_ready), 2) &&
        $past(!pix_valid && !(req_valid && req_ready), 3) &&
        $past(!pix_valid && !(req_valid && req_ready), 4) &&
        $past(!pix_valid && !(req_valid && req_ready), 5) &&
        $past(rst_n, 6) |=> !pix_valid)
        else $error("pixel without a render word");

endmodule

bind tile_background_pixel_generator_core tbpg_checker u_tbpg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_word  (pix_word)
);
